@@ rtl/core/lowest_free_room_assigner_core_defines.svh @@
// assertion macros for the core rtl top level
`ifndef LOWEST_FREE_ROOM_ASSIGNER_CORE_DEFINES_SVH
`define LOWEST_FREE_ROOM_ASSIGNER_CORE_DEFINES_SVH

// same-cycle property, checked outside reset
`define LFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define LFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lfra_pkg.sv @@
// shared constants and types of the room assigner core
package lfra_pkg;

  localparam int MaxRes = 16;
  localparam int IdxW   = 4;
  localparam int CfgW   = 5;
  localparam int TimeW  = 48;
  localparam int CntW   = 16;
  localparam int StartW = 32;

  typedef enum logic {
    PASS_SEARCH = 1'b0,
    PASS_MOST   = 1'b1
  } pass_e;

  // record walking down the cell row
  typedef struct packed {
    logic             vld;
    pass_e            kind;
    logic             found;
    logic [IdxW-1:0]  pick;
    logic [IdxW-1:0]  best_idx;
    logic [TimeW-1:0] best_time;
    logic [IdxW-1:0]  most_idx;
    logic [CntW-1:0]  most_cnt;
  } rec_t;

  // broadcast update from the control to every cell
  typedef struct packed {
    logic             wr;
    logic [IdxW-1:0]  idx;
    logic [TimeW-1:0] fin;
    logic             clr;
  } upd_t;

endpackage

@@ rtl/core/lowest_free_room_assigner_core.sv @@
// top level of the room assigner: control sequencer around a row of resource cells
// each job walks a record twice through the 16-cell row (first walk finds the room,
// second walk finds the most used room), then its result is loaded into the output register;
//   a new job is accepted only in the idle state, after the previous result has been loaded
// the output register lets the next job start while a result still waits
// reset: async active low, clears all free times and counts, resource count back to 16
`include "lowest_free_room_assigner_core_defines.svh"

module lowest_free_room_assigner_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // job in
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // [31:0] start_time, [63:32] end_time
  input  logic                      s_axis_tlast,  // last_job
  // result out
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // [3:0] assigned_resource,
                                                   // [4] was_delayed, [52:5] actual_end,
                                                   // [56:53] most_used_resource, rest zero
  output logic                      m_axis_tlast,  // last_result
  // num_resources register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lfra_pkg::CfgW-1:0] cfg_data_i
);
  import lfra_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_MOST,
    S_DONE
  } state_e;

  state_e            state_q;
  logic              inj_q;
  logic [CfgW-1:0]   cfg_q;
  logic [StartW-1:0] start_q;
  logic [StartW-1:0] dur_q;
  logic              last_q;
  logic [IdxW-1:0]   pick_q;
  logic              dly_q;
  logic [TimeW-1:0]  fin_q;
  logic [IdxW-1:0]   most_q;

  // output register
  logic              out_vld_q;
  logic [IdxW-1:0]   out_pick_q;
  logic              out_dly_q;
  logic [TimeW-1:0]  out_fin_q;
  logic [IdxW-1:0]   out_most_q;
  logic              out_last_q;

  logic [CfgW-1:0]   n_eff;
  logic [MaxRes-1:0] active_mask;
  rec_t              chain [MaxRes+1];
  rec_t              tail;
  upd_t              upd;
  logic              in_fire;
  logic              out_free;
  logic              search_done;
  logic              most_done;
  logic [TimeW-1:0]  base_time;
  logic [TimeW:0]    sum_time;
  logic [TimeW-1:0]  fin_d;
  logic [IdxW-1:0]   pick_d;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // zero acts as one, anything above the row length acts as the row length
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CfgW'(1);
    end else if (cfg_q > CfgW'(MaxRes)) begin
      n_eff = CfgW'(MaxRes);
    end else begin
      n_eff = cfg_q;
    end
  end

  for (genvar g = 0; g < MaxRes; g++) begin : g_mask
    assign active_mask[g] = (CfgW'(g) < n_eff);
  end

  // record entering cell 0 as the search and most-used states are entered
  always_comb begin
    chain[0]           = '0;
    chain[0].vld       = inj_q;
    chain[0].kind      = (state_q == S_MOST) ? PASS_MOST : PASS_SEARCH;
    chain[0].best_time = '1;
  end

  for (genvar g = 0; g < MaxRes; g++) begin : g_cell
    lfra_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IdxW'(g)),
      .active_i (active_mask[g]),
      .start_i  (start_q),
      .upd_i    (upd),
      .rec_i    (chain[g]),
      .rec_o    (chain[g+1])
    );
  end

  assign tail        = chain[MaxRes];
  assign search_done = (state_q == S_SEARCH) && tail.vld && (tail.kind == PASS_SEARCH);
  assign most_done   = (state_q == S_MOST) && tail.vld && (tail.kind == PASS_MOST);

  // free room: start plus duration; none free: earliest free time plus duration
  assign pick_d    = tail.found ? tail.pick : tail.best_idx;
  assign base_time = tail.found ? TimeW'(start_q) : tail.best_time;
  assign sum_time  = {1'b0, base_time} + (TimeW+1)'(dur_q);
  assign fin_d     = sum_time[TimeW] ? '1 : sum_time[TimeW-1:0];

  // write lands in the picked cell at the end of the search walk
  always_comb begin
    upd     = '0;
    upd.wr  = search_done;
    upd.idx = pick_d;
    upd.fin = fin_d;
    upd.clr = (state_q == S_DONE) && out_free && last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      inj_q      <= 1'b0;
      cfg_q      <= CfgW'(MaxRes);
      out_vld_q  <= 1'b0;
      start_q    <= '0;
      dur_q      <= '0;
      last_q     <= 1'b0;
      pick_q     <= '0;
      dly_q      <= 1'b0;
      fin_q      <= '0;
      most_q     <= '0;
      out_pick_q <= '0;
      out_dly_q  <= 1'b0;
      out_fin_q  <= '0;
      out_most_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      // a record enters the row after a job beat and after the search walk
      inj_q <= in_fire || search_done;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            start_q <= s_axis_tdata[31:0];
            // end below start counts as zero duration
            dur_q   <= (s_axis_tdata[63:32] > s_axis_tdata[31:0]) ?
                       (s_axis_tdata[63:32] - s_axis_tdata[31:0]) : '0;
            last_q  <= s_axis_tlast;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (search_done) begin
            pick_q  <= pick_d;
            dly_q   <= !tail.found;
            fin_q   <= fin_d;
            state_q <= S_MOST;
          end
        end
        S_MOST: begin
          if (most_done) begin
            most_q  <= tail.most_idx;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_pick_q <= pick_q;
            out_dly_q  <= dly_q;
            out_fin_q  <= fin_q;
            out_most_q <= most_q;
            out_last_q <= last_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_most_q, out_fin_q, out_dly_q, out_pick_q};
  assign m_axis_tlast  = out_last_q;

  // a job beat always starts the search walk
  `LFRA_ASSERT_NEXT(a_accept_starts_search, in_fire, (state_q == S_SEARCH) && inj_q, "accepted job did not start a search walk")
  // a record leaves the row only while a walk is expected
  `LFRA_ASSERT(a_tail_in_walk, !tail.vld || (state_q == S_SEARCH) || (state_q == S_MOST), "record left the cell row outside a walk")
  // only an enabled room is ever written
  `LFRA_ASSERT(a_pick_active, !upd.wr || active_mask[upd.idx], "job assigned to a disabled room")
  // clearing goes together with loading the final result
  `LFRA_ASSERT_NEXT(a_clear_with_last, upd.clr, out_vld_q && out_last_q, "state cleared without a last result")

endmodule

@@ rtl/core/lfra_cell.sv @@
// one resource cell: free time, use count and one hop of the walking record
module lfra_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lfra_pkg::IdxW-1:0]   idx_i,
  input  logic                        active_i,
  input  logic [lfra_pkg::StartW-1:0] start_i,
  input  lfra_pkg::upd_t              upd_i,
  input  lfra_pkg::rec_t              rec_i,
  output lfra_pkg::rec_t              rec_o
);
  import lfra_pkg::*;

  logic [TimeW-1:0] free_q;
  logic [CntW-1:0]  cnt_q;
  rec_t             rec_d, rec_q;

  always_comb begin
    rec_d = rec_i;
    if (rec_i.vld && active_i) begin
      if (rec_i.kind == PASS_SEARCH) begin
        if (!rec_i.found) begin
          if (free_q <= TimeW'(start_i)) begin
            rec_d.found = 1'b1;
            rec_d.pick  = idx_i;
          end else if (free_q < rec_i.best_time) begin
            rec_d.best_idx  = idx_i;
            rec_d.best_time = free_q;
          end
        end
      end else begin
        if (cnt_q > rec_i.most_cnt) begin
          rec_d.most_idx = idx_i;
          rec_d.most_cnt = cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
      cnt_q  <= '0;
      rec_q  <= '0;
    end else begin
      rec_q <= rec_d;
      if (upd_i.clr) begin
        free_q <= '0;
        cnt_q  <= '0;
      end else if (upd_i.wr && (upd_i.idx == idx_i)) begin
        free_q <= upd_i.fin;
        // saturating use count
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign rec_o = rec_q;

endmodule
